[hw/rtl/pbrt_pkg.sv]
`timescale 1ns / 1ps
// shared types and codes for the piece block request tracker
// no dependencies
package pbrt_pkg;

	localparam int SPAN_W = 27;

	localparam logic [2:0] ACT_INIT      = 3'd0;
	localparam logic [2:0] ACT_GET       = 3'd1;
	localparam logic [2:0] ACT_OVERLAP   = 3'd2;
	localparam logic [2:0] ACT_SET_DATA  = 3'd3;
	localparam logic [2:0] ACT_GIVE_UP   = 3'd4;
	localparam logic [2:0] ACT_HASH_FAIL = 3'd5;
	localparam logic [2:0] ACT_CLEAR     = 3'd6;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_CONFLICT  = 2'd2;
	localparam logic [1:0] ST_NO_TASK   = 2'd3;

	localparam logic [0:0] REG_PIECE_LENGTH = 1'd0;
	localparam logic [0:0] REG_PRIORITY     = 1'd1;

	localparam logic [15:0] CNT_MAX     = 16'hFFFF;
	localparam logic [15:0] LIMIT_GET   = 16'hFFFE;
	localparam logic [15:0] LIMIT_OVL_1 = 16'd1;
	localparam logic [15:0] LIMIT_OVL_2 = 16'd2;
	localparam logic signed [7:0] PRIO_OVL_1 = 8'sd5;
	localparam logic signed [7:0] PRIO_OVL_2 = 8'sd10;

	typedef struct packed {
		logic [2:0]  action;
		logic [19:0] block_offset;
		logic [31:0] source_addr;
		logic [31:0] data_tag;
	} in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [19:0] task_offset;
		logic [14:0] task_length;
		logic        finished;
		logic [15:0] fail_count;
	} out_t;

	// broadcast to every cell; the word fields stay stable while an item is in the chain
	typedef struct packed {
		logic [2:0]  op;
		logic        en;
		logic [15:0] limit;
		logic [19:0] off;
		logic [31:0] src;
		logic [31:0] tag;
		logic [15:0] fail;
		logic [20:0] plen;
	} cmd_t;

	// token passed cell to cell
	typedef struct packed {
		logic       valid;
		logic       found;
		logic       done;
		logic [1:0] status;
	} link_t;

endpackage

[hw/rtl/piece_block_request_tracker_top.sv]
`timescale 1ns / 1ps
// top level of the piece block request tracker: sequencer and a row of block cells
// depends on pbrt_pkg, pbrt_ctrl, pbrt_cell
//
//   channel  | handshake               | word
//   input    | in_valid / in_stall     | in_word (action, block_offset, source_addr, data_tag)
//   output   | out_valid / out_stall   | out_word (status, task_offset, task_length, ...)
//   config   | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// every word sends a token through all MAX_BLOCKS cells, one cell per cycle;
// get_overlap_task may take a second pass. reset clears every cell's flags, source
// and counters, the failure count and the control flags at once; no sweep follows.
// a finished result waits in the output register while the next word is taken.
module piece_block_request_tracker_top import pbrt_pkg::*; #(
	parameter int BLOCK_BYTES = 16384,
	parameter int MAX_BLOCKS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_t         in_word,
	output logic        out_valid,
	input  logic        out_stall,
	output out_t        out_word,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [20:0] cfg_data
);

	localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

	cmd_t             cmd;
	link_t            lnk [MAX_BLOCKS+1];
	logic [IDX_W-1:0] idx [MAX_BLOCKS+1];

	assign idx[0] = '0;

	pbrt_ctrl #(
		.BLOCK_BYTES(BLOCK_BYTES),
		.IDX_W(IDX_W)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word(out_word),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd(cmd),
		.lnk_head(lnk[0]),
		.lnk_tail(lnk[MAX_BLOCKS]),
		.idx_tail(idx[MAX_BLOCKS])
	);

	for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
		pbrt_cell #(
			.BLOCK_BYTES(BLOCK_BYTES),
			.IDX_W(IDX_W),
			.K(k)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.cmd(cmd),
			.lnk_in(lnk[k]),
			.idx_in(idx[k]),
			.lnk_out(lnk[k+1]),
			.idx_out(idx[k+1])
		);
	end

endmodule

[hw/rtl/pbrt_cell.sv]
`timescale 1ns / 1ps
// one block entry of the tracker table, registered hand-off to the next cell
// depends on pbrt_pkg
module pbrt_cell import pbrt_pkg::*; #(
	parameter int BLOCK_BYTES = 16384,
	parameter int IDX_W = 6,
	parameter int K = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	input  link_t            lnk_in,
	input  logic [IDX_W-1:0] idx_in,
	output link_t            lnk_out,
	output logic [IDX_W-1:0] idx_out
);

	localparam logic [SPAN_W-1:0] START = SPAN_W'(K * BLOCK_BYTES);
	localparam logic [IDX_W-1:0]  MY_IDX = IDX_W'(K);

	logic        recv_q;
	logic [31:0] tag_q;
	logic [31:0] src_q;
	logic [15:0] outs_q;
	logic [15:0] conf_q;

	logic        recv_d;
	logic [31:0] tag_d;
	logic [31:0] src_d;
	logic [15:0] outs_d;
	logic [15:0] conf_d;

	logic        in_range;
	logic        tok;
	logic        hit_get;
	logic        hit_addr;
	logic        conflict;
	logic [15:0] outs_dec;
	link_t       lnk_d;

	assign tok      = lnk_in.valid;
	assign in_range = START < SPAN_W'(cmd.plen);
	assign hit_get  = tok && in_range && cmd.en && !lnk_in.found && !recv_q
		&& (outs_q <= cmd.limit) && (cmd.op == ACT_GET || cmd.op == ACT_OVERLAP);
	assign hit_addr = tok && in_range && (SPAN_W'(cmd.off) == START)
		&& (cmd.op == ACT_SET_DATA || cmd.op == ACT_GIVE_UP);
	assign outs_dec = (outs_q == 16'd0) ? 16'd0 : outs_q - 16'd1;
	assign conflict = hit_addr && cmd.op == ACT_SET_DATA && recv_q && tag_q != cmd.tag;

	always_comb begin
		recv_d = recv_q;
		tag_d  = tag_q;
		src_d  = src_q;
		outs_d = outs_q;
		conf_d = conf_q;
		if (tok && cmd.op == ACT_INIT) begin
			recv_d = 1'b0;
			src_d  = '0;
			outs_d = '0;
			conf_d = '0;
		end else if (hit_get) begin
			outs_d = outs_q + 16'd1;
		end else if (hit_addr) begin
			outs_d = outs_dec;
			if (cmd.op == ACT_SET_DATA) begin
				if (!recv_q) begin
					recv_d = 1'b1;
					tag_d  = cmd.tag;
					src_d  = cmd.src;
				end else if (tag_q != cmd.tag) begin
					if (conf_q == 16'd0) begin
						tag_d = cmd.tag;
						src_d = cmd.src;
					end
				end else if (src_q != cmd.src && conf_q != CNT_MAX) begin
					conf_d = conf_q + 16'd1;
				end
			end
		end else if (tok && in_range && cmd.op == ACT_CLEAR && recv_q && conf_q < cmd.fail) begin
			recv_d = 1'b0;
			src_d  = '0;
		end
	end

	always_comb begin
		lnk_d        = lnk_in;
		lnk_d.found  = lnk_in.found | hit_get | hit_addr;
		lnk_d.done   = lnk_in.done & (!in_range | recv_d);
		lnk_d.status = conflict ? ST_CONFLICT : lnk_in.status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recv_q  <= 1'b0;
			src_q   <= '0;
			outs_q  <= '0;
			conf_q  <= '0;
			lnk_out <= '0;
		end else begin
			recv_q  <= recv_d;
			src_q   <= src_d;
			outs_q  <= outs_d;
			conf_q  <= conf_d;
			lnk_out <= lnk_d;
		end
	end

	always_ff @(posedge clk) begin
		tag_q   <= tag_d;
		idx_out <= hit_get ? MY_IDX : idx_in;
	end

endmodule

[hw/rtl/pbrt_ctrl.sv]
`timescale 1ns / 1ps
// sequencer: takes a word, launches the token down the cell row, builds the result
// depends on pbrt_pkg
module pbrt_ctrl import pbrt_pkg::*; #(
	parameter int BLOCK_BYTES = 16384,
	parameter int IDX_W = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_t              in_word,
	output logic             out_valid,
	input  logic             out_stall,
	output out_t             out_word,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [0:0]       cfg_index,
	input  logic [20:0]      cfg_data,
	output cmd_t             cmd,
	output link_t            lnk_head,
	input  link_t            lnk_tail,
	input  logic [IDX_W-1:0] idx_tail
);

	localparam logic [SPAN_W-1:0] BLK = SPAN_W'(BLOCK_BYTES);

	logic        busy_q;
	logic        launch_q;
	logic        pass2_q;
	logic        pend_q;
	logic        out_valid_q;
	logic [15:0] fail_q;
	logic [20:0] plen_q;
	logic [7:0]  prio_q;
	cmd_t        cmd_q;
	out_t        res_q;
	out_t        out_q;

	logic        accept;
	logic        retry;
	logic        move;
	out_t        res_d;
	logic [SPAN_W-1:0] t_off;
	logic [SPAN_W-1:0] t_rest;
	logic [SPAN_W-1:0] t_len;

	assign accept    = in_valid && !busy_q;
	assign in_stall  = busy_q;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_word  = out_q;
	assign move      = pend_q && (!out_valid_q || !out_stall);
	assign retry     = lnk_tail.valid && cmd_q.op == ACT_OVERLAP && !lnk_tail.found
		&& !pass2_q && ($signed(prio_q) > PRIO_OVL_2);

	always_comb begin
		cmd      = cmd_q;
		cmd.fail = fail_q;
		cmd.plen = plen_q;
	end

	always_comb begin
		lnk_head        = '0;
		lnk_head.valid  = launch_q;
		lnk_head.done   = 1'b1;
		lnk_head.status = ST_OK;
	end

	// offset and length of the chosen block
	assign t_off  = SPAN_W'(idx_tail) * BLK;
	assign t_rest = SPAN_W'(plen_q) - t_off;
	assign t_len  = (t_rest < BLK) ? t_rest : BLK;

	always_comb begin
		res_d             = '0;
		res_d.finished    = lnk_tail.done;
		res_d.fail_count  = fail_q;
		res_d.status      = lnk_tail.status;
		if (cmd_q.op == ACT_GET || cmd_q.op == ACT_OVERLAP) begin
			if (lnk_tail.found) begin
				res_d.task_offset = t_off[19:0];
				res_d.task_length = t_len[14:0];
			end else begin
				res_d.status = ST_NO_TASK;
			end
		end else if (cmd_q.op == ACT_SET_DATA || cmd_q.op == ACT_GIVE_UP) begin
			if (!lnk_tail.found) res_d.status = ST_NOT_FOUND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			launch_q    <= 1'b0;
			pass2_q     <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
			fail_q      <= '0;
			plen_q      <= 21'h100000;
			prio_q      <= '0;
		end else begin
			launch_q <= 1'b0;
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_PIECE_LENGTH: plen_q <= cfg_data;
					REG_PRIORITY:     prio_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (accept) begin
				busy_q   <= 1'b1;
				launch_q <= 1'b1;
				pass2_q  <= 1'b0;
				if (in_word.action == ACT_INIT) begin
					fail_q <= '0;
				end else if (in_word.action == ACT_HASH_FAIL && fail_q != CNT_MAX) begin
					fail_q <= fail_q + 16'd1;
				end
			end
			if (retry) begin
				pass2_q  <= 1'b1;
				launch_q <= 1'b1;
			end else if (lnk_tail.valid) begin
				pend_q <= 1'b1;
			end
			if (move) begin
				out_valid_q <= 1'b1;
				pend_q      <= 1'b0;
				busy_q      <= 1'b0;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q.op  <= in_word.action;
			cmd_q.off <= in_word.block_offset;
			cmd_q.src <= in_word.source_addr;
			cmd_q.tag <= in_word.data_tag;
			if (in_word.action == ACT_GET) begin
				cmd_q.en    <= $signed(prio_q) > 8'sd0;
				cmd_q.limit <= LIMIT_GET;
			end else begin
				cmd_q.en    <= $signed(prio_q) > PRIO_OVL_1;
				cmd_q.limit <= LIMIT_OVL_1;
			end
		end
		if (retry) begin
			cmd_q.limit <= LIMIT_OVL_2;
		end
		cmd_q.fail <= '0;
		cmd_q.plen <= '0;
		if (lnk_tail.valid && !retry) res_q <= res_d;
		if (move) out_q <= res_q;
	end

endmodule

[bench/pbrt_checker.sv]
`timescale 1ns / 1ps
// checker for the piece block request tracker: predicts each result word and compares
// depends on pbrt_pkg; watches the input, output and config channels of the top level
module pbrt_checker import pbrt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  in_t         in_word,
	input  logic        out_valid,
	input  logic        out_stall,
	input  out_t        out_word,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [20:0] cfg_data,
	output int          fail_total,
	output int          pending,
	output int          results_seen
);
	localparam int BLK = 16384;
	localparam int NBLK = 64;

	logic [20:0] piece_len;
	logic signed [7:0] prio;
	logic        recv [NBLK];
	logic [31:0] tag_of [NBLK];
	logic [31:0] src_of [NBLK];
	logic [15:0] outst [NBLK];
	logic [15:0] confirms [NBLK];
	logic [15:0] fails;
	out_t        expected_q [$];

	function automatic int blocks_in_piece();
		int n;
		n = (int'(piece_len) + BLK - 1) / BLK;
		return n > NBLK ? NBLK : n;
	endfunction

	function automatic int first_open(logic [15:0] lim);
		for (int k = 0; k < blocks_in_piece(); k++)
			if (!recv[k] && outst[k] <= lim) return k;
		return -1;
	endfunction

	function automatic int block_at(logic [19:0] off);
		for (int k = 0; k < blocks_in_piece(); k++)
			if (k * BLK == int'(off)) return k;
		return -1;
	endfunction

	task automatic clear_table();
		for (int k = 0; k < NBLK; k++) begin
			recv[k] = 0; tag_of[k] = 0; src_of[k] = 0; outst[k] = 0; confirms[k] = 0;
		end
		fails = 0;
	endtask

	task automatic apply_word(in_t w);
		out_t r;
		int k, n, rest;
		r = '0;
		r.status = ST_OK;
		k = -1;
		case (w.action)
			ACT_INIT: clear_table();
			ACT_GET: begin
				if (prio > 0) k = first_open(LIMIT_GET);
				if (k < 0) r.status = ST_NO_TASK;
			end
			ACT_OVERLAP: begin
				if (prio > PRIO_OVL_1) begin
					k = first_open(LIMIT_OVL_1);
					if (k < 0 && prio > PRIO_OVL_2) k = first_open(LIMIT_OVL_2);
				end
				if (k < 0) r.status = ST_NO_TASK;
			end
			ACT_SET_DATA: begin
				n = block_at(w.block_offset);
				if (n < 0) r.status = ST_NOT_FOUND;
				else begin
					if (outst[n] != 0) outst[n]--;
					if (!recv[n]) begin
						recv[n] = 1; tag_of[n] = w.data_tag; src_of[n] = w.source_addr;
					end else if (tag_of[n] != w.data_tag) begin
						if (confirms[n] == 0) begin
							tag_of[n] = w.data_tag; src_of[n] = w.source_addr;
						end
						r.status = ST_CONFLICT;
					end else if (src_of[n] != w.source_addr && confirms[n] != CNT_MAX)
						confirms[n]++;
				end
			end
			ACT_GIVE_UP: begin
				n = block_at(w.block_offset);
				if (n < 0) r.status = ST_NOT_FOUND;
				else if (outst[n] != 0) outst[n]--;
			end
			ACT_HASH_FAIL: if (fails != CNT_MAX) fails++;
			ACT_CLEAR: begin
				for (int i = 0; i < blocks_in_piece(); i++)
					if (recv[i] && confirms[i] < fails) begin
						recv[i] = 0; src_of[i] = 0;
					end
			end
			default: ;
		endcase
		if (k >= 0) begin
			outst[k]++;
			r.task_offset = 20'(k * BLK);
			rest = int'(piece_len) - k * BLK;
			r.task_length = 15'(rest < BLK ? rest : BLK);
		end
		r.finished = 1;
		for (int i = 0; i < blocks_in_piece(); i++)
			if (!recv[i]) r.finished = 0;
		r.fail_count = fails;
		expected_q = {expected_q, r};
	endtask

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		out_t e;
		if (!arst_n) begin
			piece_len = 21'd1048576;
			prio = 0;
			clear_table();
			expected_q.delete();
			fail_total = 0;
			results_seen = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_PIECE_LENGTH) piece_len = cfg_data;
				else prio = cfg_data[7:0];
			end
			if (in_valid && !in_stall) apply_word(in_word);
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_q.size() == 0) begin
					fail_total++;
					if (fail_total <= 10) $display("unexpected result word %h", out_word);
				end else begin
					e = expected_q.pop_front();
					if (e.status !== out_word.status || e.task_offset !== out_word.task_offset
							|| e.task_length !== out_word.task_length
							|| e.finished !== out_word.finished
							|| e.fail_count !== out_word.fail_count) begin
						fail_total++;
						if (fail_total <= 10)
							$display("mismatch: st %0d/%0d off %0d/%0d len %0d/%0d fin %0d/%0d fc %0d/%0d",
								e.status, out_word.status, e.task_offset, out_word.task_offset,
								e.task_length, out_word.task_length, e.finished, out_word.finished,
								e.fail_count, out_word.fail_count);
					end
				end
			end
		end
	end
endmodule

[bench/piece_block_request_tracker_top_test.sv]
`timescale 1ns / 1ps
// top of the tracker testbench: clock, reset, config phases, random words and verdict
// depends on pbrt_pkg, pbrt_checker and the piece_block_request_tracker_top rtl
module piece_block_request_tracker_top_test;
	import pbrt_pkg::*;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
	in_t  in_word;
	out_t out_word;
	logic [0:0] cfg_index;
	logic [20:0] cfg_data;
	int fail_total, pending, results_seen;
	int idle_pct;
	int idle_cycles;
	int words_sent;

	piece_block_request_tracker_top uut (.*);
	pbrt_checker chk (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// sink stalls at random, except in the no-idle stretch
	always @(posedge clk) out_stall <= ($urandom_range(99) < idle_pct);

	// watchdog on accepted traffic
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic write_reg(logic [0:0] idx, logic [20:0] val);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (2 * 64 + 10) @(posedge clk);
	endtask

	task automatic send(in_t w);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1; in_word <= w;
		do @(posedge clk); while (in_stall);
		words_sent++;
	endtask

	task automatic send_op(logic [2:0] act, logic [19:0] off, logic [31:0] src, logic [31:0] tg);
		in_t w;
		w.action = act; w.block_offset = off; w.source_addr = src; w.data_tag = tg;
		send(w);
	endtask

	// mostly aligned offsets into a few blocks, small source and tag pools for matches
	task automatic random_word(int nblk);
		in_t w;
		int r;
		r = $urandom_range(99);
		w.source_addr = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(3));
		w.data_tag = ($urandom_range(7) == 0) ? $urandom : 32'($urandom_range(2));
		w.block_offset = ($urandom_range(9) == 0) ? 20'($urandom) :
			20'($urandom_range(nblk) * 16384);
		if (r < 2) w.action = ACT_INIT;
		else if (r < 25) w.action = ACT_GET;
		else if (r < 40) w.action = ACT_OVERLAP;
		else if (r < 70) w.action = ACT_SET_DATA;
		else if (r < 82) w.action = ACT_GIVE_UP;
		else if (r < 89) w.action = ACT_HASH_FAIL;
		else if (r < 96) w.action = ACT_CLEAR;
		else w.action = 3'($urandom_range(7));
		send(w);
	endtask

	typedef struct {
		logic [20:0] plen;
		logic [7:0]  pr;
	} setting_t;

	initial begin
		setting_t phases [8];
		int nblk;
		arst_n = 0;
		in_valid = 0; in_word = '0; cfg_valid = 0; cfg_index = '0; cfg_data = '0;
		out_stall = 0;
		idle_pct = 30;
		idle_cycles = 0;
		words_sent = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reset geometry, then extremes
		write_reg(REG_PRIORITY, 21'(8'sd127));
		send_op(ACT_GET, 0, 0, 0);
		send_op(ACT_OVERLAP, 0, 0, 0);
		send_op(ACT_OVERLAP, 0, 0, 0);
		send_op(ACT_SET_DATA, 20'd16384, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_op(ACT_SET_DATA, 20'd16384, 32'h0, 32'hFFFF_FFFF);
		send_op(ACT_SET_DATA, 20'd16384, 32'h1, 32'h0);
		send_op(ACT_SET_DATA, 20'd16385, 32'h1, 32'h0);
		send_op(ACT_GIVE_UP, 20'hFFFFF, 0, 0);
		send_op(ACT_GIVE_UP, 20'd0, 0, 0);
		send_op(ACT_GIVE_UP, 20'd0, 0, 0);
		send_op(ACT_GIVE_UP, 20'd0, 0, 0);
		send_op(ACT_HASH_FAIL, 0, 0, 0);
		send_op(ACT_HASH_FAIL, 0, 0, 0);
		send_op(ACT_CLEAR, 0, 0, 0);
		send_op(3'd7, 20'hFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_op(ACT_INIT, 0, 0, 0);
		in_valid <= 0;
		drain();
		write_reg(REG_PIECE_LENGTH, 21'd0);
		send_op(ACT_GET, 0, 0, 0);
		send_op(ACT_SET_DATA, 0, 1, 1);
		send_op(ACT_GIVE_UP, 0, 1, 1);
		in_valid <= 0;
		drain();
		write_reg(REG_PIECE_LENGTH, 21'h1FFFFF);
		write_reg(REG_PRIORITY, 21'(8'h80));
		send_op(ACT_GET, 0, 0, 0);
		send_op(ACT_OVERLAP, 0, 0, 0);
		in_valid <= 0;
		drain();

		// random phases over several geometries and priorities
		phases[0] = '{21'd1, 8'd1};
		phases[1] = '{21'd40000, 8'd6};
		phases[2] = '{21'd16384, 8'd11};
		phases[3] = '{21'd100000, 8'd5};
		phases[4] = '{21'd1048576, 8'd127};
		phases[5] = '{21'd49153, 8'd10};
		phases[6] = '{21'd70000, 8'h80};
		phases[7] = '{21'd1048575, 8'd0};
		for (int p = 0; p < 8; p++) begin
			in_valid <= 0;
			drain();
			write_reg(REG_PIECE_LENGTH, phases[p].plen);
			write_reg(REG_PRIORITY, 21'(phases[p].pr));
			idle_pct = (p == 4) ? 0 : 30;
			nblk = (int'(phases[p].plen) + 16383) / 16384;
			if (nblk > 64) nblk = 64;
			nblk = nblk > 6 ? 6 : nblk;
			repeat (210) random_word(nblk);
		end
		in_valid <= 0;
		drain();
		$display("ran %0d input words over 8 config phases, %0d results checked",
			words_sent, results_seen);
		if (fail_total == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

[files.f]
hw/rtl/pbrt_pkg.sv
hw/rtl/pbrt_cell.sv
hw/rtl/pbrt_ctrl.sv
hw/rtl/piece_block_request_tracker_top.sv
bench/pbrt_checker.sv
bench/piece_block_request_tracker_top_test.sv
